// File: hw/rtl/mcpg_pkg.sv
// Shared widths, codes and divider handshake types of the MIDI clock pulse generator.
package mcpg_pkg;

    // Default values of the top-level parameters.
    localparam int PULSES_PER_QUARTER_DEF = 24;
    localparam int TICK_HZ_DEF            = 100000;
    localparam int MAX_PERIOD_DEF         = 65536;

    // Fixed constants of the timing arithmetic.
    localparam int US_PER_S  = 1000000;
    localparam int RESET_BPM = 120;

    // Field widths.
    localparam int OP_W       = 3;
    localparam int BPM_W      = 16;
    localparam int TIME_W     = 32;
    localparam int PHASE_W    = 16;
    localparam int PERIOD_W   = 17;
    localparam int IV_W       = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // The serial divider covers the widest dividend (a 32-bit time scaled by the
    // tick rate, plus rounding) and the widest divisor (tempo times pulses per quarter).
    localparam int DIV_NUM_W = 53;
    localparam int DIV_DEN_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_SET_BPM      = 3'd1,
        OP_SET_INTERVAL = 3'd2,
        OP_ALIGN        = 3'd3,
        OP_RESET_COUNTS = 3'd4,
        OP_RESET_PHASE  = 3'd5
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RT_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] numer;
        logic [DIV_DEN_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

endpackage

// File: hw/rtl/mcpg_serial_div.sv
// Restoring bit-serial divider: one quotient bit per clock cycle.
module mcpg_serial_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  mcpg_pkg::div_req_t req,
    output mcpg_pkg::div_rsp_t rsp
);

    localparam int NUM_W = mcpg_pkg::DIV_NUM_W;
    localparam int DEN_W = mcpg_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = req.numer;
            rem_next  = '0;
            den_next  = req.denom;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: hw/rtl/midi_clock_pulse_generator.sv
// Top level of the MIDI clock pulse generator: command sequencer, timing state, result register.

// The block keeps a phase counter that advances on every tick item and wraps at the
// current period; each wrap is one MIDI clock pulse, which requests a 0xF8 byte when
// the realtime output is enabled, bumps the 32-bit transport count and the quarter
// counter, and on a completed quarter note raises an internal beat unless an external
// clock is present. Every accepted item returns exactly one result item. Tick, reset
// counts, reset phase and the unused codes go from the idle state straight to the
// emit state, which loads the result register once it is free. The other commands go
// through one shared bit-serial divider that produces one quotient bit per cycle: set
// bpm and set interval need two divisions (period, then the output interval), except
// set bpm with a tempo of zero, which needs only the second; align needs three (elapsed
// ticks, then quotient and remainder by the period, then the transport count modulo the
// pulses per quarter), and align with no external pulse seen goes straight to the emit
// state. The divider is the only multi-cycle unit. A new item is accepted as soon as the
// previous one has reached the result register, even while that result still waits
// to be taken. The configuration port is always ready and is meant to be written only
// while the block is idle.
module midi_clock_pulse_generator #(
    parameter int PULSES_PER_QUARTER = mcpg_pkg::PULSES_PER_QUARTER_DEF,
    parameter int TICK_HZ            = mcpg_pkg::TICK_HZ_DEF,
    parameter int MAX_PERIOD         = mcpg_pkg::MAX_PERIOD_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcpg_pkg::CFG_DATA_W-1:0] cfg_data,

    // Input item channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mcpg_pkg::OP_W-1:0]       s_operation,
    input  logic [mcpg_pkg::BPM_W-1:0]      s_bpm,
    input  logic [mcpg_pkg::TIME_W-1:0]     s_interval_us,
    input  logic [mcpg_pkg::TIME_W-1:0]     s_now_us,
    input  logic [mcpg_pkg::TIME_W-1:0]     s_last_pulse_us,
    input  logic [mcpg_pkg::TIME_W-1:0]     s_external_pulse_count,
    input  logic                            s_transport_running,
    input  logic                            s_flash_busy,

    // Result item channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_clock_byte_request,
    output logic                            m_quarter_note,
    output logic                            m_internal_beat,
    output logic                            m_feedback_beat,
    output logic [mcpg_pkg::TIME_W-1:0]     m_beat_time_us,
    output logic [mcpg_pkg::TIME_W-1:0]     m_total_pulses,
    output logic [mcpg_pkg::PHASE_W-1:0]    m_phase_ticks,
    output logic [mcpg_pkg::PERIOD_W-1:0]   m_period_ticks,
    output logic [mcpg_pkg::IV_W-1:0]       m_pulse_interval_out_us
);

    localparam int NUM_W    = mcpg_pkg::DIV_NUM_W;
    localparam int DEN_W    = mcpg_pkg::DIV_DEN_W;
    localparam int TIME_W   = mcpg_pkg::TIME_W;
    localparam int PHASE_W  = mcpg_pkg::PHASE_W;
    localparam int PERIOD_W = mcpg_pkg::PERIOD_W;
    localparam int IV_W     = mcpg_pkg::IV_W;
    localparam int US_PER_S = mcpg_pkg::US_PER_S;

    // The quarter counter holds 0 .. PULSES_PER_QUARTER-1; one extra bit for the increment.
    localparam int QW  = $clog2(PULSES_PER_QUARTER + 1);
    localparam int QCW = QW + 1;

    localparam int US_HALF   = US_PER_S / 2;
    localparam int TICK_HALF = TICK_HZ / 2;
    localparam int BPM_NUM   = TICK_HZ * 60;

    localparam longint unsigned IV_MAX = (64'd1 << IV_W) - 64'd1;

    // Period and output interval for the reset tempo, worked out at elaboration.
    localparam longint unsigned RESET_DEN = mcpg_pkg::RESET_BPM * PULSES_PER_QUARTER;
    localparam longint unsigned RESET_RAW =
        (longint'(BPM_NUM) + RESET_DEN / 2) / RESET_DEN;
    localparam longint unsigned RESET_PERIOD =
        (RESET_RAW < 1) ? 1 : ((RESET_RAW > MAX_PERIOD) ? MAX_PERIOD : RESET_RAW);
    localparam longint unsigned RESET_IV_RAW =
        (RESET_PERIOD * US_PER_S + TICK_HALF) / TICK_HZ;
    localparam longint unsigned RESET_IV =
        (RESET_IV_RAW > IV_MAX) ? IV_MAX : RESET_IV_RAW;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PERIOD = 7'b0000010,
        ST_ALN_E  = 7'b0000100,
        ST_ALN_Q  = 7'b0001000,
        ST_ALN_M  = 7'b0010000,
        ST_IV     = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic              rt_en_reg;
    logic [TIME_W-1:0] timeout_reg;

    // Timing state.
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [QW-1:0]       quarter_reg, quarter_next;
    logic [TIME_W-1:0]   count_reg, count_next;
    logic [IV_W-1:0]     iv_reg, iv_next;

    // Fields of the item in work, captured at acceptance.
    mcpg_pkg::op_t     op_reg;
    logic [TIME_W-1:0] delta_reg;
    logic              last_zero_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] ext_reg;
    logic              running_reg;
    logic              busy_reg;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic                clk_req_reg, clk_req_next;
    logic                quarter_out_reg, quarter_out_next;
    logic                internal_reg, internal_next;
    logic                feedback_reg, feedback_next;
    logic [TIME_W-1:0]   beat_time_reg, beat_time_next;
    logic [TIME_W-1:0]   total_reg, total_next;
    logic [PHASE_W-1:0]  phase_out_reg, phase_out_next;
    logic [PERIOD_W-1:0] period_out_reg, period_out_next;
    logic [IV_W-1:0]     iv_out_reg, iv_out_next;

    mcpg_pkg::div_req_t div_req;
    mcpg_pkg::div_rsp_t div_rsp;

    logic                s_accept;
    logic [TIME_W-1:0]   delta_in;
    logic [TIME_W-1:0]   us_src;
    logic [NUM_W-1:0]    us_numer;
    logic [DEN_W-1:0]    bpm_den;
    logic [NUM_W-1:0]    bpm_numer;
    logic [PERIOD_W-1:0] period_q;
    logic [PERIOD_W-1:0] iv_src;
    logic [NUM_W-1:0]    iv_numer;
    logic [IV_W-1:0]     iv_q;
    logic                present;

    logic [PERIOD_W-1:0] ph_inc;
    logic [QCW-1:0]      q_inc;
    logic                wrap;
    logic                quarter_hit;
    logic                internal;

    mcpg_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;

    // Elapsed time since the last external pulse, modulo 2^32.
    assign delta_in = s_now_us - s_last_pulse_us;

    // Microseconds to ticks with rounding; the division by one million follows in the
    // divider. Set interval scales the given interval, align scales the elapsed time.
    assign us_src   = (s_operation == mcpg_pkg::OP_SET_INTERVAL) ? s_interval_us : delta_in;
    assign us_numer = NUM_W'(us_src) * NUM_W'(TICK_HZ) + NUM_W'(US_HALF);

    // Tempo to period: ticks per minute over pulses per minute, rounded half up.
    assign bpm_den   = DEN_W'(s_bpm) * DEN_W'(PULSES_PER_QUARTER);
    assign bpm_numer = NUM_W'(BPM_NUM) + NUM_W'(bpm_den >> 1);

    // A computed period is clamped to 1 .. MAX_PERIOD.
    assign period_q = (div_rsp.quot == '0) ? PERIOD_W'(1) :
                      (div_rsp.quot > NUM_W'(MAX_PERIOD)) ? PERIOD_W'(MAX_PERIOD) :
                      div_rsp.quot[PERIOD_W-1:0];

    // Output interval in microseconds for a new period. A tempo of zero sets the
    // longest period directly from the idle state; otherwise the period comes out of
    // the divider.
    assign iv_src   = (state_reg == ST_IDLE) ? PERIOD_W'(MAX_PERIOD) : period_q;
    assign iv_numer = NUM_W'(iv_src) * NUM_W'(US_PER_S) + NUM_W'(TICK_HALF);
    assign iv_q     = (div_rsp.quot > NUM_W'(IV_MAX)) ? '1 : div_rsp.quot[IV_W-1:0];

    // An external clock counts as present while its transport runs or while its last
    // pulse is recent enough.
    assign present = running_reg || (!last_zero_reg && (delta_reg <= timeout_reg));

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        period_next      = period_reg;
        quarter_next     = quarter_reg;
        count_next       = count_reg;
        iv_next          = iv_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        clk_req_next     = clk_req_reg;
        quarter_out_next = quarter_out_reg;
        internal_next    = internal_reg;
        feedback_next    = feedback_reg;
        beat_time_next   = beat_time_reg;
        total_next       = total_reg;
        phase_out_next   = phase_out_reg;
        period_out_next  = period_out_reg;
        iv_out_next      = iv_out_reg;
        div_req          = '0;
        ph_inc           = '0;
        q_inc            = '0;
        wrap             = 1'b0;
        quarter_hit      = 1'b0;
        internal         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EMIT;
                    case (s_operation)
                        mcpg_pkg::OP_SET_BPM: begin
                            phase_next    = '0;
                            div_req.start = 1'b1;
                            if (s_bpm == '0) begin
                                period_next   = PERIOD_W'(MAX_PERIOD);
                                div_req.numer = iv_numer;
                                div_req.denom = DEN_W'(TICK_HZ);
                                state_next    = ST_IV;
                            end else begin
                                div_req.numer = bpm_numer;
                                div_req.denom = bpm_den;
                                state_next    = ST_PERIOD;
                            end
                        end
                        mcpg_pkg::OP_SET_INTERVAL: begin
                            phase_next    = '0;
                            div_req.start = 1'b1;
                            div_req.numer = us_numer;
                            div_req.denom = DEN_W'(US_PER_S);
                            state_next    = ST_PERIOD;
                        end
                        mcpg_pkg::OP_ALIGN: begin
                            if (s_last_pulse_us != '0) begin
                                div_req.start = 1'b1;
                                div_req.numer = us_numer;
                                div_req.denom = DEN_W'(US_PER_S);
                                state_next    = ST_ALN_E;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_PERIOD: begin
                if (div_rsp.done) begin
                    period_next   = period_q;
                    div_req.start = 1'b1;
                    div_req.numer = iv_numer;
                    div_req.denom = DEN_W'(TICK_HZ);
                    state_next    = ST_IV;
                end
            end

            ST_ALN_E: begin
                // Elapsed ticks are ready; split them into whole periods and a phase.
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.numer = div_rsp.quot;
                    div_req.denom = DEN_W'(period_reg);
                    state_next    = ST_ALN_Q;
                end
            end

            ST_ALN_Q: begin
                if (div_rsp.done) begin
                    phase_next    = div_rsp.rem[PHASE_W-1:0];
                    count_next    = ext_reg + div_rsp.quot[TIME_W-1:0];
                    div_req.start = 1'b1;
                    div_req.numer = NUM_W'(count_next);
                    div_req.denom = DEN_W'(PULSES_PER_QUARTER);
                    state_next    = ST_ALN_M;
                end
            end

            ST_ALN_M: begin
                if (div_rsp.done) begin
                    quarter_next = div_rsp.rem[QW-1:0];
                    state_next   = ST_EMIT;
                end
            end

            ST_IV: begin
                if (div_rsp.done) begin
                    iv_next    = iv_q;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    case (op_reg)
                        mcpg_pkg::OP_TICK: begin
                            ph_inc = {1'b0, phase_reg} + PERIOD_W'(1);
                            wrap   = (ph_inc >= period_reg);
                            if (wrap) begin
                                phase_next = '0;
                                count_next = count_reg + TIME_W'(1);
                                q_inc      = {1'b0, quarter_reg} + QCW'(1);
                                if (q_inc >= QCW'(PULSES_PER_QUARTER)) begin
                                    quarter_next = '0;
                                    quarter_hit  = 1'b1;
                                end else begin
                                    quarter_next = q_inc[QW-1:0];
                                end
                            end else begin
                                phase_next = ph_inc[PHASE_W-1:0];
                            end
                            internal = quarter_hit && !present;
                        end
                        mcpg_pkg::OP_RESET_COUNTS: begin
                            quarter_next = '0;
                            count_next   = '0;
                        end
                        mcpg_pkg::OP_RESET_PHASE: begin
                            phase_next = '0;
                        end
                        default: begin
                        end
                    endcase

                    m_valid_next     = 1'b1;
                    clk_req_next     = wrap && rt_en_reg;
                    quarter_out_next = quarter_hit;
                    internal_next    = internal;
                    feedback_next    = internal && !busy_reg;
                    beat_time_next   = internal ? now_reg : '0;
                    total_next       = count_next;
                    phase_out_next   = phase_next;
                    period_out_next  = period_reg;
                    iv_out_next      = iv_reg;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and timing state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            phase_reg   <= '0;
            period_reg  <= PERIOD_W'(RESET_PERIOD);
            quarter_reg <= '0;
            count_reg   <= '0;
            iv_reg      <= IV_W'(RESET_IV);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            quarter_reg <= quarter_next;
            count_reg   <= count_next;
            iv_reg      <= iv_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_en_reg   <= 1'b1;
            timeout_reg <= TIME_W'(500000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mcpg_pkg::CFG_RT_ENABLE: rt_en_reg   <= cfg_data[0];
                mcpg_pkg::CFG_TIMEOUT:   timeout_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item fields are held for the whole time the item is in work.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg        <= mcpg_pkg::op_t'(s_operation);
            delta_reg     <= delta_in;
            last_zero_reg <= (s_last_pulse_us == '0);
            now_reg       <= s_now_us;
            ext_reg       <= s_external_pulse_count;
            running_reg   <= s_transport_running;
            busy_reg      <= s_flash_busy;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        clk_req_reg     <= clk_req_next;
        quarter_out_reg <= quarter_out_next;
        internal_reg    <= internal_next;
        feedback_reg    <= feedback_next;
        beat_time_reg   <= beat_time_next;
        total_reg       <= total_next;
        phase_out_reg   <= phase_out_next;
        period_out_reg  <= period_out_next;
        iv_out_reg      <= iv_out_next;
    end

    assign m_valid                 = m_valid_reg;
    assign m_clock_byte_request    = clk_req_reg;
    assign m_quarter_note          = quarter_out_reg;
    assign m_internal_beat         = internal_reg;
    assign m_feedback_beat         = feedback_reg;
    assign m_beat_time_us          = beat_time_reg;
    assign m_total_pulses          = total_reg;
    assign m_phase_ticks           = phase_out_reg;
    assign m_period_ticks          = period_out_reg;
    assign m_pulse_interval_out_us = iv_out_reg;

    // The phase always stays inside the current period.
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, phase_reg} < period_reg)
        else $error("phase counter is not below the period");

    // The quarter counter never reaches the pulses per quarter note.
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, quarter_reg} < QCW'(PULSES_PER_QUARTER))
        else $error("quarter counter out of range");

    // The divider has finished whenever a new item can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!div_rsp.busy && !div_rsp.done))
        else $error("divider still active while idle");

    // A feedback beat is always an internal beat on a completed quarter note.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_feedback_beat) |-> (m_internal_beat && m_quarter_note))
        else $error("feedback beat without internal beat");

endmodule

// File: dv/midi_clock_pulse_generator_test.sv
// Self-checking testbench of the MIDI clock pulse generator, with a built-in timing predictor.
module midi_clock_pulse_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpg_pkg::*;

    // Clock period is 12 ns. The quiet time after the last result is longer than the
    // slowest command through the divider, so the block is then surely idle.
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_ITEMS   = 500;

    // The two operation codes that the package leaves unnamed; both must change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int          PPQ        = PULSES_PER_QUARTER_DEF;
    localparam logic [63:0] TICK_RATE  = 64'(TICK_HZ_DEF);
    localparam logic [63:0] MICROS     = 64'(US_PER_S);
    localparam logic [63:0] MAX_TICKS  = 64'(MAX_PERIOD_DEF);

    // One input item of the block, field by field.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BPM_W-1:0]  bpm;
        logic [TIME_W-1:0] interval_us;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] last_pulse_us;
        logic [TIME_W-1:0] ext_count;
        logic              running;
        logic              busy;
    } clock_item_t;

    // One result item of the block, field by field.
    typedef struct {
        logic                clock_byte;
        logic                quarter;
        logic                internal;
        logic                feedback;
        logic [TIME_W-1:0]   beat_time;
        logic [TIME_W-1:0]   pulses;
        logic [PHASE_W-1:0]  phase;
        logic [PERIOD_W-1:0] period;
        logic [IV_W-1:0]     interval_out;
    } pulse_result_t;

    logic                  aclk;
    logic                  aresetn                = 1'b0;
    logic                  cfg_valid              = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index              = '0;
    logic [CFG_DATA_W-1:0] cfg_data               = '0;
    logic                  s_valid                = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation            = '0;
    logic [BPM_W-1:0]      s_bpm                  = '0;
    logic [TIME_W-1:0]     s_interval_us          = '0;
    logic [TIME_W-1:0]     s_now_us               = '0;
    logic [TIME_W-1:0]     s_last_pulse_us        = '0;
    logic [TIME_W-1:0]     s_external_pulse_count = '0;
    logic                  s_transport_running    = 1'b0;
    logic                  s_flash_busy           = 1'b0;
    logic                  m_valid;
    logic                  m_ready                = 1'b0;
    logic                  m_clock_byte_request;
    logic                  m_quarter_note;
    logic                  m_internal_beat;
    logic                  m_feedback_beat;
    logic [TIME_W-1:0]     m_beat_time_us;
    logic [TIME_W-1:0]     m_total_pulses;
    logic [PHASE_W-1:0]    m_phase_ticks;
    logic [PERIOD_W-1:0]   m_period_ticks;
    logic [IV_W-1:0]       m_pulse_interval_out_us;

    // The predictor's own copy of the timing state and of the two registers.
    logic [PHASE_W-1:0]  pred_phase;
    logic [PERIOD_W-1:0] pred_period;
    logic [4:0]          pred_quarter;
    logic [TIME_W-1:0]   pred_pulses;
    logic                rt_enable_model;
    logic [TIME_W-1:0]   timeout_model;

    // Results predicted for accepted items, oldest first.
    pulse_result_t pending_results[$];

    int fail_count      = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_remaining = 0;

    midi_clock_pulse_generator u_top (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_operation            (s_operation),
        .s_bpm                  (s_bpm),
        .s_interval_us          (s_interval_us),
        .s_now_us               (s_now_us),
        .s_last_pulse_us        (s_last_pulse_us),
        .s_external_pulse_count (s_external_pulse_count),
        .s_transport_running    (s_transport_running),
        .s_flash_busy           (s_flash_busy),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_clock_byte_request   (m_clock_byte_request),
        .m_quarter_note         (m_quarter_note),
        .m_internal_beat        (m_internal_beat),
        .m_feedback_beat        (m_feedback_beat),
        .m_beat_time_us         (m_beat_time_us),
        .m_total_pulses         (m_total_pulses),
        .m_phase_ticks          (m_phase_ticks),
        .m_period_ticks         (m_period_ticks),
        .m_pulse_interval_out_us(m_pulse_interval_out_us)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Timing arithmetic of the predictor.
    // ------------------------------------------------------------------

    // A period is always kept within one tick and the largest period.
    function automatic logic [PERIOD_W-1:0] clamp_period(input logic [63:0] p);
        if (p < 64'd1)
            return 17'd1;
        if (p > MAX_TICKS)
            return 17'(MAX_TICKS);
        return 17'(p);
    endfunction

    // Tempo to period, halves rounded up; a tempo of zero gives the longest period.
    function automatic logic [PERIOD_W-1:0] period_from_bpm(input logic [BPM_W-1:0] bpm);
        logic [63:0] den;
        den = 64'(bpm) * 64'(PPQ);
        if (den == 64'd0)
            return 17'(MAX_TICKS);
        return clamp_period((TICK_RATE * 64'd60 + den / 64'd2) / den);
    endfunction

    // Microseconds to timebase ticks, halves rounded up.
    function automatic logic [63:0] ticks_from_us(input logic [TIME_W-1:0] us);
        return (64'(us) * TICK_RATE + MICROS / 64'd2) / MICROS;
    endfunction

    task automatic reset_clock_model();
        pred_phase      = '0;
        pred_period     = period_from_bpm(16'(RESET_BPM));
        pred_quarter    = '0;
        pred_pulses     = '0;
        rt_enable_model = 1'b1;
        timeout_model   = 32'd500000;
    endtask

    // Applies one item to the predictor's state and returns the result it must produce.
    function automatic pulse_result_t advance_clock_model(input clock_item_t it);
        pulse_result_t     r;
        logic              pulse;
        logic              quarter;
        logic              internal;
        logic              present;
        logic [TIME_W-1:0] elapsed_us;
        logic [63:0]       elapsed_ticks;
        logic [63:0]       per;
        logic [63:0]       iv;
        pulse      = 1'b0;
        quarter    = 1'b0;
        internal   = 1'b0;
        elapsed_us = it.now_us - it.last_pulse_us;
        case (it.op)
            OP_TICK: begin
                if (32'(pred_phase) + 32'd1 >= 32'(pred_period)) begin
                    pred_phase = '0;
                    pulse      = 1'b1;
                end else begin
                    pred_phase = pred_phase + 16'd1;
                end
                if (pulse) begin
                    pred_pulses  = pred_pulses + 32'd1;
                    pred_quarter = pred_quarter + 5'd1;
                    if (32'(pred_quarter) >= PPQ) begin
                        pred_quarter = '0;
                        quarter      = 1'b1;
                    end
                end
                if (quarter) begin
                    // An external clock counts as present while the transport runs or
                    // while the last external pulse is recent enough.
                    present  = it.running ||
                               (it.last_pulse_us != '0 && elapsed_us <= timeout_model);
                    internal = !present;
                end
            end
            OP_SET_BPM: begin
                pred_period = period_from_bpm(it.bpm);
                pred_phase  = '0;
            end
            OP_SET_INTERVAL: begin
                pred_period = (it.interval_us == '0) ? 17'd1
                                                     : clamp_period(ticks_from_us(it.interval_us));
                pred_phase  = '0;
            end
            OP_ALIGN: begin
                // Without any external pulse seen there is nothing to align to.
                if (it.last_pulse_us != '0) begin
                    elapsed_ticks = ticks_from_us(elapsed_us);
                    per           = 64'(pred_period);
                    pred_phase    = 16'(elapsed_ticks % per);
                    pred_pulses   = it.ext_count + 32'(elapsed_ticks / per);
                    pred_quarter  = 5'(pred_pulses % PPQ);
                end
            end
            OP_RESET_COUNTS: begin
                pred_quarter = '0;
                pred_pulses  = '0;
            end
            OP_RESET_PHASE: begin
                pred_phase = '0;
            end
            default: begin
            end
        endcase
        iv = (64'(pred_period) * MICROS + TICK_RATE / 64'd2) / TICK_RATE;
        if (iv > 64'hFFFFF)
            iv = 64'hFFFFF;
        r.clock_byte   = pulse && rt_enable_model;
        r.quarter      = quarter;
        r.internal     = internal;
        r.feedback     = internal && !it.busy;
        r.beat_time    = internal ? it.now_us : '0;
        r.pulses       = pred_pulses;
        r.phase        = pred_phase;
        r.period       = pred_period;
        r.interval_out = iv[IV_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] expv,
                               input logic [63:0] actv);
        if (expv !== actv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            fail_count++;
        end
    endtask

    task automatic check_result();
        pulse_result_t want;
        if (pending_results.size() == 0) begin
            $error("result item arrived with no expected result waiting");
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("clock_byte_request", want.clock_byte, m_clock_byte_request);
            check_field("quarter_note", want.quarter, m_quarter_note);
            check_field("internal_beat", want.internal, m_internal_beat);
            check_field("feedback_beat", want.feedback, m_feedback_beat);
            check_field("beat_time_us", want.beat_time, m_beat_time_us);
            check_field("total_pulses", want.pulses, m_total_pulses);
            check_field("phase_ticks", want.phase, m_phase_ticks);
            check_field("period_ticks", want.period, m_period_ticks);
            check_field("pulse_interval_out_us", want.interval_out, m_pulse_interval_out_us);
        end
    endtask

    // The monitor watches all three channels at each rising edge. Ports are read
    // before the edge's updates land, so it sees exactly what the block sampled.
    // A result is always checked before the item accepted at the same edge is
    // predicted; an item's own result can never appear at its acceptance edge.
    initial begin : channel_monitor
        clock_item_t seen;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                reset_clock_model();
                pending_results.delete();
            end else begin
                if (m_valid && m_ready)
                    check_result();
                if (cfg_valid && cfg_ready) begin
                    case (cfg_index)
                        CFG_RT_ENABLE: rt_enable_model = cfg_data[0];
                        CFG_TIMEOUT:   timeout_model   = cfg_data;
                        default: begin
                        end
                    endcase
                end
                if (s_valid && s_ready) begin
                    seen.op            = s_operation;
                    seen.bpm           = s_bpm;
                    seen.interval_us   = s_interval_us;
                    seen.now_us        = s_now_us;
                    seen.last_pulse_us = s_last_pulse_us;
                    seen.ext_count     = s_external_pulse_count;
                    seen.running       = s_transport_running;
                    seen.busy          = s_flash_busy;
                    pending_results.push_back(advance_clock_model(seen));
                end
            end
        end
    end

    // The receiver takes results at random, or holds off completely while a stall
    // has been requested. The stall is counted down here, one cycle per edge.
    initial begin : result_ready_driver
        forever begin
            @(posedge aclk);
            if (stall_remaining > 0) begin
                m_ready <= 1'b0;
                stall_remaining--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving.
    // ------------------------------------------------------------------

    // Offers one item after a random gap and returns at the edge that accepts it.
    // Valid stays high when the next item follows without a gap, so it is never
    // lowered and raised again within one time step.
    task automatic send_item(input clock_item_t it);
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid                <= 1'b1;
        s_operation            <= it.op;
        s_bpm                  <= it.bpm;
        s_interval_us          <= it.interval_us;
        s_now_us               <= it.now_us;
        s_last_pulse_us        <= it.last_pulse_us;
        s_external_pulse_count <= it.ext_count;
        s_transport_running    <= it.running;
        s_flash_busy           <= it.busy;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops offering items and waits until every expected result has been taken,
    // then lets the block settle for longer than its slowest command.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic clock_item_t make_item(
        input logic [OP_W-1:0] op, input logic [BPM_W-1:0] bpm,
        input logic [TIME_W-1:0] interval_us, input logic [TIME_W-1:0] now_us,
        input logic [TIME_W-1:0] last_pulse_us, input logic [TIME_W-1:0] ext_count,
        input logic running, input logic busy);
        clock_item_t it;
        it.op            = op;
        it.bpm           = bpm;
        it.interval_us   = interval_us;
        it.now_us        = now_us;
        it.last_pulse_us = last_pulse_us;
        it.ext_count     = ext_count;
        it.running       = running;
        it.busy          = busy;
        return it;
    endfunction

    // Random item, shaped so that pulses and quarter notes keep coming: most items
    // are ticks, periods are usually set short, and the time since the last external
    // pulse is often placed right at the activity timeout.
    function automatic clock_item_t random_item();
        clock_item_t       it;
        logic [TIME_W-1:0] delta;
        int                pick;
        it.bpm         = 16'($urandom);
        it.interval_us = $urandom;
        it.now_us      = $urandom;
        it.ext_count   = $urandom;
        it.running     = ($urandom_range(99) < 20);
        it.busy        = 1'($urandom_range(1));
        case ($urandom_range(2))
            0:       delta = timeout_model + 32'($urandom_range(6)) - 32'd3;
            1:       delta = 32'($urandom_range(5000));
            default: delta = $urandom;
        endcase
        it.last_pulse_us = it.now_us - delta;
        if ($urandom_range(99) < 12)
            it.last_pulse_us = '0;
        pick = $urandom_range(99);
        if (pick < 74) begin
            it.op = OP_TICK;
        end else if (pick < 81) begin
            it.op = OP_SET_INTERVAL;
            if ($urandom_range(3) != 0)
                it.interval_us = 32'($urandom_range(40));
        end else if (pick < 85) begin
            it.op = OP_SET_BPM;
            if ($urandom_range(1) != 0)
                it.bpm = 16'($urandom_range(65535, 40000));
        end else if (pick < 92) begin
            it.op = OP_ALIGN;
        end else if (pick < 95) begin
            it.op = OP_RESET_COUNTS;
        end else if (pick < 98) begin
            it.op = OP_RESET_PHASE;
        end else begin
            it.op = ($urandom_range(1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A single tick straight after reset shows the reset period of 120 bpm.
    task automatic test_reset_state();
        send_item(make_item(OP_TICK, '0, '0, '0, '0, '0, 1'b0, 1'b0));
    endtask

    // Tempo and interval commands at their extremes, including the saturating
    // zero tempo, the clamp at the longest period and the rounding of halves.
    // The last command leaves a period of one tick for the tests that follow.
    task automatic test_tempo_commands();
        send_item(make_item(OP_SET_BPM, 16'd0, '0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_BPM, 16'd1, '0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_BPM, 16'hFFFF, '0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_BPM, 16'd120, '0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_INTERVAL, '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_INTERVAL, '0, 32'd4, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_INTERVAL, '0, 32'd15, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_SET_INTERVAL, '0, 32'd0, '0, '0, '0, 1'b0, 1'b0));
    endtask

    // Align with no external pulse seen, across the wrap of the microsecond timer,
    // and with the longest possible elapsed time.
    task automatic test_align_phase();
        send_item(make_item(OP_ALIGN, '0, '0, 32'd123, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_item(make_item(OP_ALIGN, '0, '0, 32'd5, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                            1'b0, 1'b0));
        send_item(make_item(OP_ALIGN, '0, '0, 32'd0, 32'd1, 32'd0, 1'b0, 1'b0));
    endtask

    // Each align puts the quarter counter one pulse before a quarter note, so the
    // following tick completes one. The ticks cover no external clock, a running
    // transport, an external pulse exactly at the timeout, and one just past it
    // while flash is busy.
    task automatic test_quarter_notes();
        send_item(make_item(OP_ALIGN, '0, '0, 32'd1000, 32'd1000, 32'd23, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, '0, '0, 32'hFFFF_FFFF, 32'd0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_ALIGN, '0, '0, 32'd1000, 32'd1000, 32'd47, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, '0, '0, 32'd77, 32'd0, '0, 1'b1, 1'b0));
        send_item(make_item(OP_ALIGN, '0, '0, 32'd1000, 32'd1000, 32'd71, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, '0, '0, 32'd600000, 32'd100000, '0, 1'b0, 1'b1));
        send_item(make_item(OP_ALIGN, '0, '0, 32'd1000, 32'd1000, 32'd95, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, '0, '0, 32'd600001, 32'd100000, '0, 1'b0, 1'b1));
    endtask

    // Count and phase resets, and the two unused codes that must leave all alone.
    task automatic test_resets();
        send_item(make_item(OP_RESET_COUNTS, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_RESET_PHASE, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        send_item(make_item(OP_UNUSED_6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_item(make_item(OP_UNUSED_7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    endtask

    // With the output disabled and a zero timeout, an external pulse in the same
    // microsecond still counts as present, one microsecond later it does not.
    task automatic test_register_extremes();
        wait_until_drained();
        write_register(CFG_RT_ENABLE, 32'd0);
        write_register(CFG_TIMEOUT, 32'd0);
        send_item(make_item(OP_ALIGN, '0, '0, 32'd9, 32'd9, 32'd23, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, '0, '0, 32'd5, 32'd5, '0, 1'b0, 1'b0));
        send_item(make_item(OP_ALIGN, '0, '0, 32'd9, 32'd9, 32'd47, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, '0, '0, 32'd6, 32'd5, '0, 1'b0, 1'b0));
        wait_until_drained();
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_item(random_item());
    endtask

    // The receiver stalls for a long stretch while ticks keep coming, so the result
    // register and the item in flight fill up and the input must stall too.
    task automatic test_backpressure();
        clock_item_t it;
        stall_remaining = HOLDOFF_CYCLES;
        repeat (40) begin
            it    = random_item();
            it.op = OP_TICK;
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------

    initial begin : test_sequence
        send_idle_pct = 32;
        recv_idle_pct = 53;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_register(CFG_RT_ENABLE, 32'd1);
        write_register(CFG_TIMEOUT, 32'd500000);
        test_reset_state();
        test_tempo_commands();
        test_align_phase();
        test_quarter_notes();
        test_resets();
        test_register_extremes();

        // First random phase: sender idles less than the receiver.
        write_register(CFG_RT_ENABLE, 32'd1);
        write_register(CFG_TIMEOUT, 32'($urandom_range(1000000)));
        test_random_traffic(RANDOM_ITEMS);
        test_backpressure();
        wait_until_drained();

        // Second phase: the idle rates swap, output off, timeout at its maximum.
        send_idle_pct = 53;
        recv_idle_pct = 32;
        write_register(CFG_RT_ENABLE, 32'd0);
        write_register(CFG_TIMEOUT, 32'hFFFF_FFFF);
        test_random_traffic(RANDOM_ITEMS);
        wait_until_drained();

        // Third phase: neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_RT_ENABLE, 32'd1);
        write_register(CFG_TIMEOUT, $urandom);
        test_random_traffic(RANDOM_ITEMS);
        wait_until_drained();

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Safety net far beyond the slowest correct run.
    initial begin : run_limit
        #(20_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
